[sv/dlm_pkg.sv]
// ----------------------------------------------------------------------------
// dlm_pkg: shared types and constants of the DFA longest-match unit
// Field widths, opcodes, the input item record and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package dlm_pkg;

    // Default sizing of the automaton storage.
    localparam int DLM_NUM_STATES      = 256;
    localparam int DLM_SLOTS_PER_STATE = 16;
    localparam int DLM_MAX_LENGTH      = 4096;

    // Fixed field widths.
    localparam int OPCODE_W = 2;
    localparam int BYTE_W   = 8;
    localparam int SLOTIX_W = 4;
    localparam int RCOUNT_W = 5;
    localparam int LENGTH_W = 13;

    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 24;

    // Register file.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_START_STATE = 1'b0;   // word select paddr[2]

    localparam logic [BYTE_W-1:0] START_STATE_RESET = 8'd1;

    // Item opcodes.
    localparam logic [OPCODE_W-1:0] OP_SLOT  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_INFO  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_BYTE  = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_EMPTY = 2'd3;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [BYTE_W-1:0]   state_index;
        logic [SLOTIX_W-1:0] slot_index;
        logic [BYTE_W-1:0]   range_low;
        logic [BYTE_W-1:0]   range_high;
        logic [BYTE_W-1:0]   target_state;
        logic [BYTE_W-1:0]   accept_code;
        logic [RCOUNT_W-1:0] range_count;
        logic [BYTE_W-1:0]   symbol;
        logic                last_symbol;
    } t_item;

    // One transition slot as stored in the slot memory.
    typedef struct packed {
        logic [BYTE_W-1:0] tgt;
        logic [BYTE_W-1:0] hi;
        logic [BYTE_W-1:0] lo;
    } t_slot;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic wr_slot;   // store the item's transition slot
        logic wr_info;   // store the item's accept code and slot count
        logic take;      // capture a live byte, restart the slot scan
        logic clear;     // restart the string at the start state
        logic note;      // record the current state if it accepts
        logic slot_inc;  // move the scan to the next slot
        logic commit;    // take the scan result as the new state
        logic emit;      // load the result register, restart the string
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic dead;
        logic last;
        logic scan_done;
        logic next_zero;
        logic out_free;
    } t_dp_sts;

endpackage

[sv/dfa_longest_match_unit.sv]
// ----------------------------------------------------------------------------
// dfa_longest_match_unit: longest-prefix matcher over a range-labelled DFA
// Loads a transition table and per-state accept codes, then reports the
// longest accepted prefix of each byte string and its token type.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                      Payload
//  s_axis    in         s_axis_tvalid / s_axis_tready   tuser opcode, tdata, tlast
//  m_axis    out        m_axis_tvalid / m_axis_tready   tdata result
//  APB       in/out     psel & penable, pready = 1      start_state at 0x0
//
//  Slot and state info writes are taken in the idle state. A live byte gets
//  an accept check, then a scan over the slots of its state, one slot per
//  cycle through the single read port of the slot memory (at most
//  SLOTS_PER_STATE slots); the last byte of a string adds the final accept
//  check and the result hand-off, or only the hand-off when that byte leads
//  to the dead state. A byte after the dead state is only consumed, or handed
//  off when it ends the string; an empty-string request gets the check and hand-off.
//  Reset is synchronous and active low; the memories keep their contents.
//  A result waits in its register while m_axis_tready is low; the unit keeps
//  taking items until a second result needs that register.
//
module dfa_longest_match_unit
    import dlm_pkg::*;
#(
    parameter int NUM_STATES      = DLM_NUM_STATES,
    parameter int SLOTS_PER_STATE = DLM_SLOTS_PER_STATE,
    parameter int MAX_LENGTH      = DLM_MAX_LENGTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata, low bit first: state_index[7:0], slot_index[11:8],
    // range_low[19:12], range_high[27:20], target_state[35:28],
    // accept_code[43:36], range_count[48:44], symbol[56:49], zeros above.
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    // tuser: opcode[1:0].
    input  logic [OPCODE_W-1:0]   s_axis_tuser,
    input  logic                  s_axis_tlast,

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata, low bit first: match_found[0], match_length[13:1],
    // token_type[21:14], zeros above.
    output logic [M_TDATA_W-1:0]  m_axis_tdata,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_item               item;
    t_dp_cmd             cmd;
    t_dp_sts             sts;
    logic [BYTE_W-1:0]   r_start_state;
    logic                cfg_wr;
    logic                item_valid;
    logic                match_found;
    logic [LENGTH_W-1:0] match_length;
    logic [BYTE_W-1:0]   token_type;

    // Unpack the input transfer into its fields.
    assign item.opcode       = s_axis_tuser;
    assign item.state_index  = s_axis_tdata[7:0];
    assign item.slot_index   = s_axis_tdata[11:8];
    assign item.range_low    = s_axis_tdata[19:12];
    assign item.range_high   = s_axis_tdata[27:20];
    assign item.target_state = s_axis_tdata[35:28];
    assign item.accept_code  = s_axis_tdata[43:36];
    assign item.range_count  = s_axis_tdata[48:44];
    assign item.symbol       = s_axis_tdata[56:49];
    assign item.last_symbol  = s_axis_tlast;

    // The controller only acts on an item in its idle state, where it also
    // raises tready, so valid alone marks an accepted transfer there.
    assign item_valid = s_axis_tvalid;

    // Register block: one register, start_state, in the word at offset 0.
    // The word is selected by paddr[2]; the byte offset bits are ignored.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_START_STATE);
    assign prdata = (paddr[2] == REG_START_STATE)
                  ? APB_DATA_W'(r_start_state) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_state <= START_STATE_RESET;
        end else if (cfg_wr) begin
            r_start_state <= pwdata[BYTE_W-1:0];
        end
    end

    dlm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (item_valid),
        .i_opcode (item.opcode),
        .i_last   (item.last_symbol),
        .o_ready  (s_axis_tready),
        .i_sts    (sts),
        .o_cmd    (cmd)
    );

    dlm_datapath #(
        .NUM_STATES      (NUM_STATES),
        .SLOTS_PER_STATE (SLOTS_PER_STATE),
        .MAX_LENGTH      (MAX_LENGTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (item),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_start_state  (r_start_state),
        .i_cfg_wr       (cfg_wr),
        .i_cfg_state    (pwdata[BYTE_W-1:0]),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_match_found  (match_found),
        .o_match_length (match_length),
        .o_token_type   (token_type)
    );

    // Pack the result transfer.
    assign m_axis_tdata = {2'b00, token_type, match_length, match_found};

endmodule

[sv/dlm_ctrl.sv]
// ----------------------------------------------------------------------------
// dlm_ctrl: sequencer of the DFA longest-match unit
// Decodes accepted items and steps the datapath through the accept check,
// the ordered slot scan, the final accept check and the result hand-off.
// ----------------------------------------------------------------------------
module dlm_ctrl
    import dlm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [OPCODE_W-1:0] i_opcode,
    input  logic                i_last,
    output logic                o_ready,
    input  t_dp_sts             i_sts,
    output t_dp_cmd             o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_INFO  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_FINAL = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    unique case (i_opcode)
                        OP_SLOT: o_cmd.wr_slot = 1'b1;
                        OP_INFO: o_cmd.wr_info = 1'b1;
                        OP_EMPTY: begin
                            o_cmd.clear = 1'b1;
                            n_state     = S_FINAL;
                        end
                        OP_BYTE: begin
                            if (i_sts.dead) begin
                                // Bytes after the dead state only count for the end mark.
                                if (i_last) begin
                                    n_state = S_EMIT;
                                end
                            end else begin
                                o_cmd.take = 1'b1;
                                n_state    = S_INFO;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_INFO: begin
                o_cmd.note = 1'b1;
                n_state    = S_SCAN;
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    o_cmd.commit = 1'b1;
                    if (i_sts.last) begin
                        n_state = i_sts.next_zero ? S_EMIT : S_FINAL;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    o_cmd.slot_inc = 1'b1;
                end
            end
            S_FINAL: begin
                o_cmd.note = 1'b1;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[sv/dlm_datapath.sv]
// ----------------------------------------------------------------------------
// dlm_datapath: storage and match state of the DFA longest-match unit
// Holds the slot memory, the state info memory, the running match state,
// the range comparator and the result register.
// ----------------------------------------------------------------------------
module dlm_datapath
    import dlm_pkg::*;
#(
    parameter int NUM_STATES      = DLM_NUM_STATES,
    parameter int SLOTS_PER_STATE = DLM_SLOTS_PER_STATE,
    parameter int MAX_LENGTH      = DLM_MAX_LENGTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_item               i_item,
    input  t_dp_cmd             i_cmd,
    output t_dp_sts             o_sts,
    input  logic [BYTE_W-1:0]   i_start_state,
    input  logic                i_cfg_wr,
    input  logic [BYTE_W-1:0]   i_cfg_state,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic                o_match_found,
    output logic [LENGTH_W-1:0] o_match_length,
    output logic [BYTE_W-1:0]   o_token_type
);

    localparam int SA_W     = $clog2(NUM_STATES);
    localparam int SL_W     = (SLOTS_PER_STATE > 1) ? $clog2(SLOTS_PER_STATE) : 1;
    localparam int CNT_W    = $clog2(SLOTS_PER_STATE + 1);
    localparam int POS_W    = $clog2(MAX_LENGTH + 1);
    localparam int TT_DEPTH = NUM_STATES * (2 ** SL_W);
    localparam int INFO_W   = BYTE_W + CNT_W;

    // Memories.
    t_slot             r_tt_mem   [TT_DEPTH];
    logic [INFO_W-1:0] r_info_mem [NUM_STATES];
    t_slot             r_tt_q;
    logic [INFO_W-1:0] r_info_q;

    // Match state.
    logic [BYTE_W-1:0] r_cur,       n_cur;
    logic [POS_W-1:0]  r_pos,       n_pos;
    logic [POS_W-1:0]  r_best_len,  n_best_len;
    logic [BYTE_W-1:0] r_best_type, n_best_type;
    logic              r_have,      n_have;
    logic              r_dead,      n_dead;
    logic [CNT_W-1:0]  r_slot,      n_slot;
    logic [BYTE_W-1:0] r_sym;
    logic              r_last;

    // Result register.
    logic                r_out_valid, n_out_valid;
    logic                r_out_found;
    logic [LENGTH_W-1:0] r_out_len;
    logic [BYTE_W-1:0]   r_out_type;

    logic                   slot_ok;
    logic                   info_ok;
    logic [SA_W+SL_W-1:0]   tt_wr_addr;
    logic [SA_W+SL_W-1:0]   tt_rd_addr;
    logic [CNT_W-1:0]       cnt_sat;
    logic                   cur_valid;
    logic [BYTE_W-1:0]      acc_eff;
    logic [CNT_W-1:0]       info_cnt;
    logic                   scan_end;
    logic                   in_range;
    logic [BYTE_W-1:0]      next_state;
    logic [POS_W-1:0]       pos_inc;

    assign slot_ok = (32'(i_item.state_index) < NUM_STATES)
                  && (32'(i_item.slot_index) < SLOTS_PER_STATE);
    assign info_ok = (32'(i_item.state_index) < NUM_STATES);
    assign tt_wr_addr = {SA_W'(i_item.state_index), SL_W'(i_item.slot_index)};
    assign cnt_sat = (32'(i_item.range_count) > SLOTS_PER_STATE)
                   ? CNT_W'(SLOTS_PER_STATE) : CNT_W'(i_item.range_count);

    // States outside the table neither accept nor leave anywhere.
    assign cur_valid = (32'(r_cur) < NUM_STATES);
    assign acc_eff   = cur_valid ? r_info_q[INFO_W-1 -: BYTE_W] : '0;
    assign info_cnt  = r_info_q[CNT_W-1:0];

    assign scan_end   = !cur_valid || (r_slot >= info_cnt);
    assign in_range   = (r_tt_q.lo <= r_sym) && (r_sym <= r_tt_q.hi);
    assign next_state = scan_end ? '0 : r_tt_q.tgt;
    assign pos_inc    = (32'(r_pos) < MAX_LENGTH) ? r_pos + POS_W'(1) : r_pos;

    assign o_sts.dead      = r_dead;
    assign o_sts.last      = r_last;
    assign o_sts.scan_done = scan_end || in_range;
    assign o_sts.next_zero = (next_state == '0);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        n_cur       = r_cur;
        n_pos       = r_pos;
        n_best_len  = r_best_len;
        n_best_type = r_best_type;
        n_have      = r_have;
        n_dead      = r_dead;
        n_slot      = r_slot;
        n_out_valid = r_out_valid;

        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (i_cmd.take) begin
            n_slot = '0;
        end
        if (i_cmd.slot_inc) begin
            n_slot = r_slot + CNT_W'(1);
        end
        if (i_cmd.note && (acc_eff != '0)) begin
            n_have      = 1'b1;
            n_best_len  = r_pos;
            n_best_type = acc_eff - BYTE_W'(1);
        end
        if (i_cmd.commit) begin
            n_cur  = next_state;
            n_pos  = pos_inc;
            n_dead = (next_state == '0);
        end
        if (i_cmd.emit) begin
            n_out_valid = 1'b1;
        end
        if (i_cmd.clear || i_cmd.emit) begin
            n_cur       = i_start_state;
            n_pos       = '0;
            n_best_len  = '0;
            n_best_type = '0;
            n_have      = 1'b0;
            n_dead      = 1'b0;
        end
        // A new start state applies at once while the position is zero.
        if (i_cfg_wr && (r_pos == '0) && !r_dead) begin
            n_cur = i_cfg_state;
        end
    end

    // Reads follow the next state and slot, so the read registers always
    // hold the entries of the registered state and slot.
    assign tt_rd_addr = {SA_W'(n_cur), n_slot[SL_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_slot && slot_ok) begin
            r_tt_mem[tt_wr_addr] <= '{tgt: i_item.target_state,
                                      hi:  i_item.range_high,
                                      lo:  i_item.range_low};
        end
        r_tt_q <= r_tt_mem[tt_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_info && info_ok) begin
            r_info_mem[SA_W'(i_item.state_index)] <= {i_item.accept_code, cnt_sat};
        end
        r_info_q <= r_info_mem[SA_W'(n_cur)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur       <= START_STATE_RESET;
            r_pos       <= '0;
            r_best_len  <= '0;
            r_best_type <= '0;
            r_have      <= 1'b0;
            r_dead      <= 1'b0;
            r_slot      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cur       <= n_cur;
            r_pos       <= n_pos;
            r_best_len  <= n_best_len;
            r_best_type <= n_best_type;
            r_have      <= n_have;
            r_dead      <= n_dead;
            r_slot      <= n_slot;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_sym  <= i_item.symbol;
            r_last <= i_item.last_symbol;
        end
        if (i_cmd.emit) begin
            r_out_found <= r_have;
            r_out_len   <= r_have ? LENGTH_W'(r_best_len) : '0;
            r_out_type  <= r_have ? r_best_type : '0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_match_found  = r_out_found;
    assign o_match_length = r_out_len;
    assign o_token_type   = r_out_type;

endmodule

[sv/dlm_checker.sv]
// ----------------------------------------------------------------------------
// dlm_checker: port-level checks of the DFA longest-match unit
// Watches the stream ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module dlm_checker
    import dlm_pkg::*;
#(
    parameter int MAX_LENGTH = DLM_MAX_LENGTH
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic [OPCODE_W-1:0]  s_axis_tuser,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata
);

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result pending after reset");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // A miss reports zero length and zero token type.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[21:1] == '0)
        else $error("miss carries a length or type");

    // The empty-string request keeps the unit busy for its accept check.
    a_empty_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_EMPTY)
        |=> !s_axis_tready)
        else $error("input ready right after an empty-string request");

    // The reported length never passes the saturation limit.
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> 32'(m_axis_tdata[13:1]) <= MAX_LENGTH)
        else $error("match length above limit");

endmodule

bind dfa_longest_match_unit dlm_checker #(
    .MAX_LENGTH (MAX_LENGTH)
) u_dlm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
